>>> hw/rtl/piecewise_linear_rate_table_assert.svh
// Assertion macros for the piecewise-linear rate table checker.
`ifndef PIECEWISE_LINEAR_RATE_TABLE_ASSERT_SVH
`define PIECEWISE_LINEAR_RATE_TABLE_ASSERT_SVH

// Next-cycle implication, switched off while reset is held.
`define PLRT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plrt: assertion failed");

// Next-cycle implication that also holds across reset.
`define PLRT_ASSERT_NEXT_NR(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("plrt: assertion failed");

`endif

>>> hw/rtl/plrt_pkg.sv
// Package for the piecewise-linear rate table: sizes, codes, states and control structs.
`default_nettype none

package plrt_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int TIME_W     = 32;
  localparam int RATE_W     = 32;
  localparam int ENTRY_W    = TIME_W + RATE_W;
  localparam int DIV_CNT_W  = $clog2(TIME_W);

  // item kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRIME,
    S_LOAD,
    S_CMP,
    S_MUL,
    S_DSTART,
    S_DIV,
    S_FIN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic idx_load;
    logic rd_en;
    logic hi_load;
    logic op_load;
    logic mul_en;
    logic div_init;
    logic div_step;
    logic fin;
    logic nomatch;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic few_points;
    logic match;
    logic seg_zero;
    logic div_last;
  } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/plrt_if.sv
// Request and response channel interfaces of the rate table.
`default_nettype none

interface plrt_req_if import plrt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [TIME_W-1:0]        time_value;
  logic signed [RATE_W-1:0] rate_value;

  modport source (output valid, kind, time_value, rate_value, input ready);
  modport sink   (input valid, kind, time_value, rate_value, output ready);
endinterface

interface plrt_rsp_if import plrt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] result_rate;
  logic [1:0]               status;

  modport source (output valid, result_rate, status, input ready);
  modport sink   (input valid, result_rate, status, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/plrt_dp.sv
// Datapath: breakpoint store, backward segment scan, multiplier and serial divider.
`default_nettype none

module plrt_dp import plrt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic [1:0]               kind,
  input  logic [TIME_W-1:0]        time_value,
  input  logic signed [RATE_W-1:0] rate_value,
  output logic signed [RATE_W-1:0] result_rate,
  output logic [1:0]               status
);

  logic [ENTRY_W-1:0]       mem [MAX_POINTS];
  logic [CNT_W-1:0]         count;
  logic signed [RATE_W-1:0] held;
  logic [1:0]               st;
  logic [TIME_W-1:0]        qt;
  logic [IDX_W-1:0]         idx;
  logic [ENTRY_W-1:0]       rd_q;
  logic [IDX_W-1:0]         rd_idx;
  logic [TIME_W-1:0]        hi_time;
  logic [RATE_W-1:0]        hi_rate;
  logic [RATE_W-1:0]        lo_rate;
  logic                     neg;
  logic [RATE_W-1:0]        mag;
  logic [TIME_W-1:0]        dt;
  logic [TIME_W-1:0]        span;
  logic [RATE_W+TIME_W-1:0] prod;
  logic [TIME_W-1:0]        rem;
  logic [RATE_W-1:0]        qsh;
  logic [DIV_CNT_W-1:0]     dcnt;

  logic                     full;
  logic [TIME_W-1:0]        rd_time;
  logic [RATE_W-1:0]        rd_rate;
  logic [RATE_W:0]          diff;
  logic [RATE_W:0]          diff_neg;
  logic [RATE_W+TIME_W-1:0] prod_c;
  logic [TIME_W:0]          rem_sh;
  logic                     qbit;
  logic [RATE_W:0]          sum;

  assign full    = (count == CNT_W'(MAX_POINTS));
  assign rd_time = rd_q[ENTRY_W-1:RATE_W];
  assign rd_rate = rd_q[RATE_W-1:0];
  assign diff    = {hi_rate[RATE_W-1], hi_rate} - {rd_rate[RATE_W-1], rd_rate};
  assign diff_neg = -diff;
  assign prod_c  = mag * dt;
  assign rem_sh  = {rem, qsh[RATE_W-1]};
  assign qbit    = (rem_sh >= {1'b0, span});
  assign sum     = neg ? ({lo_rate[RATE_W-1], lo_rate} - {1'b0, qsh})
                       : ({lo_rate[RATE_W-1], lo_rate} + {1'b0, qsh});

  assign stat.few_points = (count < CNT_W'(2));
  assign stat.match      = (rd_time <= qt) && (qt < hi_time);
  assign stat.seg_zero   = (rd_idx == '0);
  assign stat.div_last   = (dcnt == '1);

  // store write, append only when room is left
  always_ff @(posedge clk) begin
    if (cmd.accept && kind == KIND_APPEND && !full) begin
      mem[count[IDX_W-1:0]] <= {time_value, rate_value};
    end
  end

  // store read, registered
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q   <= mem[idx];
      rd_idx <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      held  <= '0;
    end else begin
      if (cmd.accept) begin
        case (kind)
          KIND_CLEAR:  count <= '0;
          KIND_APPEND: if (!full) count <= count + CNT_W'(1);
          default:     ;
        endcase
      end
      if (cmd.fin) held <= sum[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) qt <= time_value;

    // no-match comes with the accept of a short-table query (or ends a fruitless scan), so it takes priority
    if (cmd.nomatch) begin
      st <= ST_NOMATCH;
    end else if (cmd.fin) begin
      st <= ST_OK;
    end else if (cmd.accept) begin
      st <= (kind == KIND_APPEND && full) ? ST_FULL : ST_OK;
    end

    if (cmd.idx_load)  idx <= IDX_W'(count - CNT_W'(1));
    else if (cmd.rd_en) idx <= idx - IDX_W'(1);

    if (cmd.hi_load) begin
      hi_time <= rd_time;
      hi_rate <= rd_rate;
    end

    if (cmd.op_load) begin
      lo_rate <= rd_rate;
      neg     <= diff[RATE_W];
      mag     <= diff[RATE_W] ? diff_neg[RATE_W-1:0] : diff[RATE_W-1:0];
      dt      <= qt - rd_time;
      span    <= hi_time - rd_time;
    end

    if (cmd.mul_en) prod <= prod_c;

    // restoring division; the high half is below span, so 32 steps suffice
    if (cmd.div_init) begin
      rem  <= prod[RATE_W+TIME_W-1:RATE_W];
      qsh  <= prod[RATE_W-1:0];
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= qbit ? TIME_W'(rem_sh - {1'b0, span}) : rem_sh[TIME_W-1:0];
      qsh  <= {qsh[RATE_W-2:0], qbit};
      dcnt <= dcnt + DIV_CNT_W'(1);
    end

    if (cmd.out_load) begin
      result_rate <= held;
      status      <= st;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/plrt_ctrl.sv
// Controller: sequences accept, segment scan, multiply, divide and response transfer.
`default_nettype none

module plrt_ctrl import plrt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  output logic       out_valid,
  input  logic       out_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_QUERY && !stat.few_points) state_next = S_PRIME;
          else state_next = S_RESP;
        end
      end
      S_PRIME:  state_next = S_LOAD;
      S_LOAD:   state_next = S_CMP;
      S_CMP: begin
        if (stat.match) state_next = S_MUL;
        else if (stat.seg_zero) state_next = S_RESP;
      end
      S_MUL:    state_next = S_DSTART;
      S_DSTART: state_next = S_DIV;
      S_DIV: begin
        if (stat.div_last) state_next = S_FIN;
      end
      S_FIN:    state_next = S_RESP;
      S_RESP: begin
        if (slot_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.accept   = in_valid;
        cmd.idx_load = in_valid;
        cmd.nomatch  = in_valid && kind == KIND_QUERY && stat.few_points;
      end
      S_PRIME:  cmd.rd_en = 1'b1;
      S_LOAD: begin
        cmd.rd_en   = 1'b1;
        cmd.hi_load = 1'b1;
      end
      S_CMP: begin
        cmd.op_load = 1'b1;
        cmd.rd_en   = !stat.match;
        cmd.hi_load = !stat.match;
        cmd.nomatch = !stat.match && stat.seg_zero;
      end
      S_MUL:    cmd.mul_en   = 1'b1;
      S_DSTART: cmd.div_init = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_FIN:    cmd.fin      = 1'b1;
      S_RESP:   cmd.out_load = slot_free;
      default:  ;
    endcase
  end

  // response slot: filled by out_load, emptied by a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/piecewise_linear_rate_table.sv
// Top level of the piecewise-linear rate table: controller plus datapath.
//
// Keeps up to MAX_POINTS (time, rate) breakpoints and answers queries by linear
// interpolation. Each request transfer (kind 0 clear, 1 append, 2 query) gives
// exactly one response transfer carrying the held rate (signed Q16.16) and a
// status: 0 ok, 1 table full and the append dropped, 2 no segment matched (held
// rate kept). A query looks for segment i with time[i] <= t < time[i+1]; where
// several match, the highest i wins. The rate is
// rate[i] + (rate[i+1]-rate[i]) * (t-time[i]) / (time[i+1]-time[i]), product
// taken exactly, quotient truncated toward zero. Timing: one item is in flight
// at a time. Clear, append, unused kind three and queries on fewer than two
// points go from the accept straight to the response state and its register.
// A query walks the segments from the top down, one per cycle through the
// single registered read port of the breakpoint store, stopping at the first
// hit; then a 32x32 multiply and a 32-step restoring divide follow. A query
// that finds nothing goes to the response state instead. A finished result
// sits in the response register while the next request is taken. The store
// needs no clearing pass after reset.
`default_nettype none

module piecewise_linear_rate_table import plrt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  plrt_req_if.sink   req,
  plrt_rsp_if.source rsp
);

  cmd_t  cmd;
  stat_t stat;

  plrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .kind      (req.kind),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  plrt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .kind        (req.kind),
    .time_value  (req.time_value),
    .rate_value  (req.rate_value),
    .result_rate (rsp.result_rate),
    .status      (rsp.status)
  );

endmodule

`default_nettype wire

>>> hw/rtl/plrt_checker.sv
// Port-level checker for the rate table, bound to the top level.
`default_nettype none
`include "piecewise_linear_rate_table_assert.svh"

module plrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_result_rate,
  input logic [1:0]  rsp_status
);

  // a stalled response holds its payload
  `PLRT_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_rate) && $stable(rsp_status))

  // one item in flight: a request transfer closes the request side
  `PLRT_ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready)

  // reset leaves the block empty and ready
  `PLRT_ASSERT_NEXT_NR(a_reset_state, clk, rst, req_ready && !rsp_valid)

endmodule

bind piecewise_linear_rate_table plrt_checker u_plrt_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_result_rate (rsp.result_rate),
  .rsp_status      (rsp.status)
);

`default_nettype wire
